// ===== design/rau_pkg.sv =====
// Package for the rational arithmetic unit: widths, codes, states, helpers.
package rau_pkg;
    localparam int OPERAND_WIDTH = 16;
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int MW = PW + 1;
    localparam int CW = $clog2(MW + 1);
    localparam int OUT_W = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_GCD,
        ST_GSHIFT,
        ST_DIV,
        ST_DONE
    } t_state;

    // Signed-magnitude value to 32-bit two's complement with saturation.
    function automatic logic [OUT_W-1:0] to_out32(input logic neg, input logic [MW-1:0] mag);
        logic [63:0] m64;
        logic [63:0] neg64;
        m64 = 64'(mag);
        neg64 = 64'd0 - m64;
        if (neg) begin
            to_out32 = (m64 >= 64'h8000_0000) ? 32'h8000_0000 : neg64[OUT_W-1:0];
        end else begin
            to_out32 = (m64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m64[OUT_W-1:0];
        end
    endfunction
endpackage

// ===== design/rau_if.sv =====
// Handshake interfaces for operand items and result items.
interface rau_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              op;
    logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_num;
    logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_den;
    logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_num;
    logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_den;
    modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [rau_pkg::OUT_W-1:0] res_num;
    logic signed [rau_pkg::OUT_W-1:0] res_den;
    logic                            negative;
    logic                            zero_error;
    modport source (output valid, res_num, res_den, negative, zero_error, input ready);
    modport sink   (input valid, res_num, res_den, negative, zero_error, output ready);
endinterface

// ===== design/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: cross-multiply, binary gcd, divide out, one shared datapath.
// Sequence: products on the shared multiplier, a sum, binary gcd steps plus one
// doubling per common factor of two, then a restoring divide of numerator and
// denominator by the gcd, one quotient bit per step. Gcd and divide are skipped
// when both raw parts are zero; the unit takes one item at a time.
// Reset (synchronous, active low) returns the sequencer to idle and drops valid.
module rational_arithmetic_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rau_in_if.sink        i_in,
    rau_out_if.source     o_out
);
    localparam int W  = rau_pkg::OPERAND_WIDTH;
    localparam int PW = rau_pkg::PW;
    localparam int MW = rau_pkg::MW;
    localparam int CW = rau_pkg::CW;

    rau_pkg::t_state r_state, n_state;

    // captured operands as sign and magnitude
    logic [1:0]      r_op, n_op;
    logic [3:0]      r_sgn, n_sgn;
    logic [W-1:0]    r_mag [4];
    logic [W-1:0]    n_mag [4];

    // products: term of numerator, denominator, second numerator term
    logic            r_p0_s, n_p0_s, r_p1_s, n_p1_s, r_p2_s, n_p2_s;
    logic [PW-1:0]   r_p0, n_p0, r_p1, n_p1, r_p2, n_p2;

    // raw signed-magnitude results
    logic            r_num_s, n_num_s, r_den_s, n_den_s;
    logic [MW-1:0]   r_num, n_num, r_den, n_den;

    // gcd working pair, common-twos count, divider
    logic [MW-1:0]   r_x, n_x, r_y, n_y;
    logic [CW-1:0]   r_k, n_k, r_cnt, n_cnt;
    logic [MW-1:0]   r_q, n_q;
    logic [MW:0]     r_rem, n_rem;
    logic            r_sel, n_sel;     // 0 dividing numerator, 1 denominator
    logic [MW-1:0]   r_qn, n_qn;       // reduced numerator magnitude
    logic            r_zero, n_zero;

    // shared multiplier
    logic [W-1:0]    mul_a, mul_b;
    logic [PW-1:0]   mul_p;
    logic            mul_s;

    // adder scratch
    logic            t_s;
    logic [MW-1:0]   ma, mb;
    logic [MW:0]     rem_sh;

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_sgn   <= n_sgn;
        for (int i = 0; i < 4; i++) begin
            r_mag[i] <= n_mag[i];
        end
        r_p0_s  <= n_p0_s;  r_p0 <= n_p0;
        r_p1_s  <= n_p1_s;  r_p1 <= n_p1;
        r_p2_s  <= n_p2_s;  r_p2 <= n_p2;
        r_num_s <= n_num_s; r_num <= n_num;
        r_den_s <= n_den_s; r_den <= n_den;
        r_x     <= n_x;     r_y   <= n_y;
        r_k     <= n_k;     r_cnt <= n_cnt;
        r_q     <= n_q;     r_rem <= n_rem;
        r_sel   <= n_sel;   r_qn  <= n_qn;
        r_zero  <= n_zero;
    end

    always_comb begin
        n_state = r_state;
        n_op = r_op;   n_sgn = r_sgn;
        for (int i = 0; i < 4; i++) begin
            n_mag[i] = r_mag[i];
        end
        n_p0_s = r_p0_s; n_p0 = r_p0;
        n_p1_s = r_p1_s; n_p1 = r_p1;
        n_p2_s = r_p2_s; n_p2 = r_p2;
        n_num_s = r_num_s; n_num = r_num;
        n_den_s = r_den_s; n_den = r_den;
        n_x = r_x; n_y = r_y; n_k = r_k; n_cnt = r_cnt;
        n_q = r_q; n_rem = r_rem; n_sel = r_sel; n_qn = r_qn;
        n_zero = r_zero;
        mul_a = r_mag[1];
        mul_b = r_mag[2];
        mul_s = 1'b0;
        t_s = 1'b0;
        ma = '0;
        mb = '0;
        rem_sh = '0;
        i_in.ready = 1'b0;
        o_out.valid = 1'b0;

        case (r_state)
            rau_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_op = i_in.op;
                    n_sgn = {i_in.b_den[W-1], i_in.b_num[W-1], i_in.a_den[W-1], i_in.a_num[W-1]};
                    n_mag[0] = i_in.a_num[W-1] ? W'(-i_in.a_num) : i_in.a_num;
                    n_mag[1] = i_in.a_den[W-1] ? W'(-i_in.a_den) : i_in.a_den;
                    n_mag[2] = i_in.b_num[W-1] ? W'(-i_in.b_num) : i_in.b_num;
                    n_mag[3] = i_in.b_den[W-1] ? W'(-i_in.b_den) : i_in.b_den;
                    n_cnt = '0;
                    n_state = rau_pkg::ST_MUL;
                end
            end
            rau_pkg::ST_MUL: begin
                // step 0: numerator term, 1: denominator, 2: cross term
                case (r_cnt[1:0])
                    2'd0: begin
                        mul_a = r_mag[0];
                        mul_b = (r_op == rau_pkg::OP_MUL) ? r_mag[2] : r_mag[3];
                        mul_s = r_sgn[0] ^ ((r_op == rau_pkg::OP_MUL) ? r_sgn[2] : r_sgn[3]);
                        n_p0 = mul_p;
                        n_p0_s = mul_s && (mul_p != '0);
                    end
                    2'd1: begin
                        mul_a = r_mag[1];
                        mul_b = (r_op == rau_pkg::OP_DIV) ? r_mag[2] : r_mag[3];
                        mul_s = r_sgn[1] ^ ((r_op == rau_pkg::OP_DIV) ? r_sgn[2] : r_sgn[3]);
                        n_p1 = mul_p;
                        n_p1_s = mul_s && (mul_p != '0);
                    end
                    default: begin
                        mul_a = r_mag[1];
                        mul_b = r_mag[2];
                        mul_s = r_sgn[1] ^ r_sgn[2];
                        n_p2 = mul_p;
                        n_p2_s = mul_s && (mul_p != '0);
                    end
                endcase
                n_cnt = r_cnt + CW'(1);
                if (r_cnt[1:0] == 2'd2) begin
                    n_state = rau_pkg::ST_SUM;
                end
            end
            rau_pkg::ST_SUM: begin
                ma = MW'(r_p0);
                mb = MW'(r_p2);
                t_s = (r_op == rau_pkg::OP_SUB) ? (r_p2_s ^ (r_p2 != '0)) : r_p2_s;
                if (r_op == rau_pkg::OP_ADD || r_op == rau_pkg::OP_SUB) begin
                    if (r_p0_s == t_s) begin
                        n_num = ma + mb;
                        n_num_s = r_p0_s;
                    end else if (ma >= mb) begin
                        n_num = ma - mb;
                        n_num_s = r_p0_s;
                    end else begin
                        n_num = mb - ma;
                        n_num_s = t_s;
                    end
                    if (n_num == '0) begin
                        n_num_s = 1'b0;
                    end
                end else begin
                    n_num = ma;
                    n_num_s = r_p0_s;
                end
                n_den = MW'(r_p1);
                n_den_s = r_p1_s;
                n_x = n_num;
                n_y = n_den;
                n_k = '0;
                n_zero = (n_num == '0) && (n_den == '0);
                if (n_zero) begin
                    n_state = rau_pkg::ST_DONE;
                end else if (n_num == '0 || n_den == '0) begin
                    // gcd is the other part
                    n_x = n_num | n_den;
                    n_state = rau_pkg::ST_GSHIFT;
                end else begin
                    n_state = rau_pkg::ST_GCD;
                end
            end
            rau_pkg::ST_GCD: begin
                // binary gcd, one step per cycle
                if (r_y == '0) begin
                    n_state = rau_pkg::ST_GSHIFT;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + CW'(1);
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (r_x >= r_y) begin
                    n_x = r_y;
                    n_y = r_x - r_y;
                end else begin
                    n_y = r_y - r_x;
                end
            end
            rau_pkg::ST_GSHIFT: begin
                if (r_k == '0) begin
                    n_q = r_num;
                    n_rem = '0;
                    n_cnt = '0;
                    n_sel = 1'b0;
                    n_state = rau_pkg::ST_DIV;
                end else begin
                    n_x = r_x << 1;
                    n_k = r_k - CW'(1);
                end
            end
            rau_pkg::ST_DIV: begin
                // restoring divide by the gcd held in r_x
                rem_sh = {r_rem[MW-1:0], r_q[MW-1]};
                if (rem_sh >= {1'b0, r_x}) begin
                    n_rem = rem_sh - {1'b0, r_x};
                    n_q = {r_q[MW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_q = {r_q[MW-2:0], 1'b0};
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(MW - 1)) begin
                    n_cnt = '0;
                    if (!r_sel) begin
                        n_qn = n_q;
                        n_q = r_den;
                        n_rem = '0;
                        n_sel = 1'b1;
                    end else begin
                        n_state = rau_pkg::ST_DONE;
                    end
                end
            end
            rau_pkg::ST_DONE: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    n_state = rau_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rau_pkg::ST_IDLE;
            end
        endcase
    end

    // result fields; after the den pass r_q holds the reduced denominator
    assign o_out.res_num    = r_zero ? '0 : rau_pkg::to_out32(r_num_s, r_qn);
    assign o_out.res_den    = r_zero ? '0 : rau_pkg::to_out32(r_den_s, r_q);
    assign o_out.negative   = !r_zero && (r_num_s || r_den_s);
    assign o_out.zero_error = r_zero;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("accepted a second item while busy");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("result pending while ready");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rau_pkg::ST_DIV) |-> (r_cnt < CW'(MW)))
        else $error("divider count overran");
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.zero_error) |-> (o_out.res_num == '0 && o_out.res_den == '0))
        else $error("zero error with nonzero result");
`endif
endmodule

// ===== tb/sv/rau_checker.sv =====
// Checker for the rational arithmetic unit: predicts each result and compares it.
`timescale 1ns / 1ps
module rau_checker (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rau_in_if.sink   i_in_mon,
    rau_out_if.sink  i_out_mon,
    output int       o_fail_count,
    output int       o_pending
);
    typedef struct packed {
        logic signed [rau_pkg::OUT_W-1:0] res_num;
        logic signed [rau_pkg::OUT_W-1:0] res_den;
        logic                             negative;
        logic                             zero_error;
    } t_fraction;

    t_fraction fractions_due[$];

    // Signed product as sign plus magnitude.
    function automatic void sm_mul(input longint x, input longint y,
                                   output bit neg, output longint unsigned mag);
        longint p;
        p = x * y;
        neg = p < 0;
        mag = neg ? -p : p;
    endfunction

    function automatic void sm_add(input bit xn, input longint unsigned xm,
                                   input bit yn, input longint unsigned ym,
                                   output bit neg, output longint unsigned mag);
        if (xn == yn) begin
            neg = xn; mag = xm + ym;
        end else if (xm >= ym) begin
            neg = xn; mag = xm - ym;
        end else begin
            neg = yn; mag = ym - xm;
        end
        if (mag == 0) neg = 0;
    endfunction

    function automatic logic [31:0] clamp32(input bit neg, input longint unsigned mag);
        if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic t_fraction reduce_fraction(input rau_pkg::t_op op, input longint an,
                                                  input longint ad, input longint bn,
                                                  input longint bd);
        bit nn, dn, pn, qn;
        longint unsigned nm, dm, pm, qm, x, y, r;
        t_fraction f;
        case (op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                sm_mul(an, bd, pn, pm);
                sm_mul(ad, bn, qn, qm);
                if (op == rau_pkg::OP_SUB && qm != 0) qn = !qn;
                sm_add(pn, pm, qn, qm, nn, nm);
                sm_mul(ad, bd, dn, dm);
            end
            rau_pkg::OP_MUL: begin
                sm_mul(an, bn, nn, nm);
                sm_mul(ad, bd, dn, dm);
            end
            default: begin
                sm_mul(an, bd, nn, nm);
                sm_mul(ad, bn, dn, dm);
            end
        endcase
        if (nm == 0 && dm == 0) begin
            f = '0;
            f.zero_error = 1'b1;
            return f;
        end
        x = nm; y = dm;
        while (y != 0) begin
            r = x % y; x = y; y = r;
        end
        f.res_num = clamp32(nn, nm / x);
        f.res_den = clamp32(dn, dm / x);
        f.negative = nn || dn;
        f.zero_error = 1'b0;
        return f;
    endfunction

    always_ff @(posedge i_clk) begin
        t_fraction exp_f;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                fractions_due.push_back(reduce_fraction(rau_pkg::t_op'(i_in_mon.op),
                    i_in_mon.a_num, i_in_mon.a_den, i_in_mon.b_num, i_in_mon.b_den));
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (fractions_due.size() == 0) begin
                    $error("result with no item outstanding");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_f = fractions_due.pop_front();
                    if (i_out_mon.res_num !== exp_f.res_num ||
                        i_out_mon.res_den !== exp_f.res_den ||
                        i_out_mon.negative !== exp_f.negative ||
                        i_out_mon.zero_error !== exp_f.zero_error)
                        o_fail_count <= o_fail_count + 1;
                    if (i_out_mon.res_num !== exp_f.res_num)
                        $error("res_num expected %0d got %0d", exp_f.res_num,
                               i_out_mon.res_num);
                    if (i_out_mon.res_den !== exp_f.res_den)
                        $error("res_den expected %0d got %0d", exp_f.res_den,
                               i_out_mon.res_den);
                    if (i_out_mon.negative !== exp_f.negative)
                        $error("negative expected %0b got %0b", exp_f.negative,
                               i_out_mon.negative);
                    if (i_out_mon.zero_error !== exp_f.zero_error)
                        $error("zero_error expected %0b got %0b", exp_f.zero_error,
                               i_out_mon.zero_error);
                end
            end
        end
    end

    assign o_pending = fractions_due.size();
endmodule

// ===== tb/sv/rational_arithmetic_unit_test.sv =====
// Testbench top for the rational arithmetic unit: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module rational_arithmetic_unit_test;
    localparam int N_RANDOM = 1630;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   stim_done = 1'b0;
    bit   hold_off = 1'b0;
    int   results_seen = 0;

    rau_in_if  in_ch();
    rau_out_if out_ch();

    always #5 i_clk = ~i_clk;

    rational_arithmetic_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    rau_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch.sink),
        .i_out_mon   (out_ch.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Operand picker: mostly small values so reductions are common, plus extremes.
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 12)) - 16'd6;
            2: return ($urandom_range(0, 1)) ? 16'h8000 : 16'h7FFF;
            3: return 16'($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 200)) - 16'd100;
        endcase
    endfunction

    task automatic send_item(input rau_pkg::t_op op, input logic [15:0] an,
                             input logic [15:0] ad, input logic [15:0] bn,
                             input logic [15:0] bd);
        int gap;
        gap = $urandom_range(0, 15);
        // Drop valid only when a gap follows; a zero gap keeps it high.
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.a_num <= an;
        in_ch.a_den <= ad;
        in_ch.b_num <= bn;
        in_ch.b_den <= bd;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Sender
    initial begin
        in_ch.valid = 1'b0;
        in_ch.op = '0;
        in_ch.a_num = '0;
        in_ch.a_den = '0;
        in_ch.b_num = '0;
        in_ch.b_den = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: extremes, every op, zero parts, both parts zero.
        send_item(rau_pkg::OP_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(rau_pkg::OP_SUB, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_item(rau_pkg::OP_MUL, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_item(rau_pkg::OP_DIV, 16'h8000, 16'h0001, 16'h0001, 16'h8000);
        send_item(rau_pkg::OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        send_item(rau_pkg::OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        send_item(rau_pkg::OP_MUL, 16'd0, 16'd5, 16'd3, 16'd7);
        send_item(rau_pkg::OP_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
        send_item(rau_pkg::OP_MUL, 16'd0, 16'd0, 16'd3, 16'd7);
        send_item(rau_pkg::OP_DIV, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(rau_pkg::OP_ADD, 16'hFFFF, 16'd3, 16'd2, 16'hFFFA);
        send_item(rau_pkg::OP_SUB, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(rau_pkg::OP_MUL, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_item(rau_pkg::OP_DIV, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_item(rau_pkg::OP_ADD, 16'd6, 16'd4, 16'd9, 16'd6);
        send_item(rau_pkg::OP_SUB, 16'h0000, 16'h0003, 16'h0000, 16'h0005);
        send_item(rau_pkg::OP_MUL, 16'd48, 16'd64, 16'd128, 16'd96);
        send_item(rau_pkg::OP_DIV, 16'hFFF0, 16'd7, 16'd14, 16'hFFF0);
        send_item(rau_pkg::OP_ADD, 16'd0, 16'd0, 16'd1, 16'd1);
        send_item(rau_pkg::OP_ADD, 16'd1, 16'd0, 16'd0, 16'd1);
        for (int i = 0; i < N_RANDOM; i++)
            send_item(rau_pkg::t_op'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                      pick_operand(), pick_operand());
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver, with one long hold-off early on so the input side stalls.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (results_seen == 30) begin
                hold_off = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (1500) @(posedge i_clk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            results_seen++;
        end
    end

    // Watchdog on cycles with no accepted item on either side, outside the hold-off.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/rau_pkg.sv
design/rau_if.sv
design/rational_arithmetic_unit.sv
tb/sv/rau_checker.sv
tb/sv/rational_arithmetic_unit_test.sv
